@@ rtl/core/tcpop_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP option parser package
// Shared constants, parse phase encoding and the result record that passes
// from the option walker to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpop_pkg;

  // Largest option area that is honored; a longer area length is clamped.
  localparam int unsigned MAX_AREA_BYTES = 40;
  localparam logic [5:0]  AREA_LIMIT     = 6'(MAX_AREA_BYTES);

  // Option kinds.
  localparam logic [7:0] K_END    = 8'd0;
  localparam logic [7:0] K_NOP    = 8'd1;
  localparam logic [7:0] K_MSS    = 8'd2;
  localparam logic [7:0] K_WSCALE = 8'd3;
  localparam logic [7:0] K_SACKP  = 8'd4;
  localparam logic [7:0] K_TS     = 8'd8;

  // Fixed field sizes of the known options, in bytes.
  localparam logic [7:0] MSS_BYTES    = 8'd2;
  localparam logic [7:0] WSCALE_BYTES = 8'd1;
  localparam logic [7:0] TS_BYTES     = 8'd8;

  // Bytes of the kind and length header of an option.
  localparam logic [7:0] OPT_HDR_BYTES = 8'd2;

  // Timestamp option overhead taken off the peer MSS.
  localparam logic [15:0] TS_OVERHEAD = 16'd12;

  // Position counter saturates here.
  localparam logic [5:0] POS_MAX = 6'd63;

  typedef enum logic [2:0] {
    PH_KIND,
    PH_LEN,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic mss;
    logic wscale;
    logic sack;
    logic ts;
  } seen_t;

  // Parse result of one option area, as seen after its last item.
  typedef struct packed {
    seen_t        seen;
    logic [15:0]  mss;
    logic [7:0]   wscale;
    logic [31:0]  ts_val;
    logic [31:0]  ts_ecr;
    logic [31:0]  ts_time;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/tcpop_walk.sv @@
// ----------------------------------------------------------------------------
// TCP option walker
// Steps through the option area one byte per item, tracking the kind and
// length of each option and collecting the fields of the known options.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpop_walk
  import tcpop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  opt_byte,
  input  wire logic        has_byte,
  input  wire logic [5:0]  area_length,
  input  wire logic        last_byte,
  input  wire logic [31:0] current_time,
  output res_t             res_nxt
);

  phase_t       phase_r, phase_nxt;
  logic [7:0]   kind_r, kind_nxt;
  logic [7:0]   left_r, left_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  accum_r, accum_nxt;
  seen_t        seen_r, seen_nxt;
  logic [15:0]  mss_r, mss_nxt;
  logic [7:0]   wscale_r, wscale_nxt;
  logic [31:0]  ts_val_r, ts_val_nxt;
  logic [31:0]  ts_ecr_r, ts_ecr_nxt;
  logic [31:0]  ts_time_r, ts_time_nxt;

  logic [5:0]   lim;
  logic         use_byte;
  logic         len_bad;
  logic [63:0]  accum_shift;
  logic [7:0]   left_dec;

  // Byte qualification and length checks shared by both blocks below.
  always_comb begin
    lim         = (area_length > AREA_LIMIT) ? AREA_LIMIT : area_length;
    use_byte    = has_byte && (pos_r < lim);
    len_bad     = (opt_byte < OPT_HDR_BYTES) ||
                  (({3'b000, pos_r} + {1'b0, opt_byte}) > ({3'b000, lim} + 9'd1));
    accum_shift = {accum_r[55:0], opt_byte};
    left_dec    = (left_r != 8'd0) ? (left_r - 8'd1) : left_r;
  end

  // Next parse phase.
  always_comb begin
    phase_nxt = phase_r;
    if (use_byte) begin
      case (phase_r)
        PH_KIND: begin
          if (opt_byte == K_END) begin
            phase_nxt = PH_DONE;
          end else if (opt_byte != K_NOP) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (len_bad) begin
            phase_nxt = PH_DONE;
          end else if ((kind_r == K_MSS) || (kind_r == K_WSCALE) || (kind_r == K_TS)) begin
            phase_nxt = PH_DATA;
          end else if (kind_r == K_SACKP) begin
            phase_nxt = PH_KIND;
          end else if (opt_byte == OPT_HDR_BYTES) begin
            phase_nxt = PH_KIND;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_DATA, PH_SKIP: begin
          if (left_dec == 8'd0) begin
            phase_nxt = PH_KIND;
          end
        end
        default: phase_nxt = PH_DONE;
      endcase
    end
  end

  // Field collection, counters and recorded option values.
  always_comb begin
    kind_nxt    = kind_r;
    left_nxt    = left_r;
    accum_nxt   = accum_r;
    seen_nxt    = seen_r;
    mss_nxt     = mss_r;
    wscale_nxt  = wscale_r;
    ts_val_nxt  = ts_val_r;
    ts_ecr_nxt  = ts_ecr_r;
    ts_time_nxt = ts_time_r;
    pos_nxt     = pos_r;

    if (has_byte && (pos_r != POS_MAX)) begin
      pos_nxt = pos_r + 6'd1;
    end

    if (use_byte) begin
      case (phase_r)
        PH_KIND: begin
          if ((opt_byte != K_END) && (opt_byte != K_NOP)) begin
            kind_nxt = opt_byte;
          end
        end
        PH_LEN: begin
          if (!len_bad) begin
            accum_nxt = 64'd0;
            if (kind_r == K_MSS) begin
              left_nxt = MSS_BYTES;
            end else if (kind_r == K_WSCALE) begin
              left_nxt = WSCALE_BYTES;
            end else if (kind_r == K_TS) begin
              left_nxt = TS_BYTES;
            end else if (kind_r == K_SACKP) begin
              seen_nxt.sack = 1'b1;
            end else begin
              left_nxt = opt_byte - OPT_HDR_BYTES;
            end
          end
        end
        PH_DATA: begin
          accum_nxt = accum_shift;
          left_nxt  = left_dec;
          // The last field byte completes the option.
          if (left_dec == 8'd0) begin
            case (kind_r)
              K_MSS: begin
                mss_nxt      = accum_shift[15:0];
                seen_nxt.mss = 1'b1;
              end
              K_WSCALE: begin
                wscale_nxt      = accum_shift[7:0];
                seen_nxt.wscale = 1'b1;
              end
              K_TS: begin
                ts_val_nxt  = accum_shift[63:32];
                ts_ecr_nxt  = accum_shift[31:0];
                ts_time_nxt = current_time;
                seen_nxt.ts = 1'b1;
              end
              default: ;
            endcase
          end
        end
        PH_SKIP: begin
          left_nxt = left_dec;
        end
        default: ;
      endcase
    end
  end

  // The result reflects the state after this item.
  assign res_nxt = '{seen: seen_nxt, mss: mss_nxt, wscale: wscale_nxt,
                     ts_val: ts_val_nxt, ts_ecr: ts_ecr_nxt, ts_time: ts_time_nxt};

  // Parser state; the last item of an area returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      phase_r   <= PH_KIND;
      kind_r    <= 8'd0;
      left_r    <= 8'd0;
      pos_r     <= 6'd0;
      accum_r   <= 64'd0;
      seen_r    <= '0;
      mss_r     <= 16'd0;
      wscale_r  <= 8'd0;
      ts_val_r  <= 32'd0;
      ts_ecr_r  <= 32'd0;
      ts_time_r <= 32'd0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      left_r    <= left_nxt;
      pos_r     <= pos_nxt;
      accum_r   <= accum_nxt;
      seen_r    <= seen_nxt;
      mss_r     <= mss_nxt;
      wscale_r  <= wscale_nxt;
      ts_val_r  <= ts_val_nxt;
      ts_ecr_r  <= ts_ecr_nxt;
      ts_time_r <= ts_time_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Field and skip phases always have bytes still to come.
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_DATA) || (phase_r == PH_SKIP)) |-> (left_r != 8'd0))
    else $error("walker in data or skip phase with no bytes left");

  // An unseen MSS option leaves its value at zero.
  a_mss_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r.mss |-> (mss_r == 16'd0))
    else $error("mss value set without mss seen");

  // The last item of an area starts the next area from scratch.
  a_area_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last_byte) |=> ((phase_r == PH_KIND) && (seen_r == '0) && (pos_r == 6'd0)))
    else $error("parser state not cleared after last item");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tcpop_out.sv @@
// ----------------------------------------------------------------------------
// TCP option parser output stage
// Holds the timestamp enable register and the result register, and forms
// the effective MSS as the result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpop_out
  import tcpop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        load,
  input  wire res_t        res_in,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_mss_seen,
  output logic [15:0]      out_mss_value,
  output logic [15:0]      out_eff_mss,
  output logic             out_wscale_seen,
  output logic [7:0]       out_wscale_value,
  output logic             out_sack_permitted,
  output logic             out_ts_seen,
  output logic [31:0]      out_ts_value,
  output logic [31:0]      out_ts_echo,
  output logic [31:0]      out_ts_update_time
);

  logic        ts_en_r;
  logic        valid_r;
  res_t        res_r;
  logic [15:0] eff_r, eff_nxt;

  // Timestamp enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      ts_en_r <= cfg_wr_data;
    end
  end

  // Effective MSS; zero when no MSS option was found.
  always_comb begin
    eff_nxt = 16'd0;
    if (res_in.seen.mss) begin
      eff_nxt = ts_en_r ? (res_in.mss - TS_OVERHEAD) : res_in.mss;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
      eff_r <= eff_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_mss_seen       = res_r.seen.mss;
  assign out_mss_value      = res_r.mss;
  assign out_eff_mss        = eff_r;
  assign out_wscale_seen    = res_r.seen.wscale;
  assign out_wscale_value   = res_r.wscale;
  assign out_sack_permitted = res_r.seen.sack;
  assign out_ts_seen        = res_r.seen.ts;
  assign out_ts_value       = res_r.ts_val;
  assign out_ts_echo        = res_r.ts_ecr;
  assign out_ts_update_time = res_r.ts_time;

endmodule

`default_nettype wire

@@ rtl/core/tcp_option_parser.sv @@
// ----------------------------------------------------------------------------
// TCP option parser
// Walks the TCP option area one byte per item and reports MSS, window
// scale, SACK permitted and timestamp options on the last item of the area.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Handshake            Carries
//  in_*        input      in_valid/in_ready    one option byte with area info
//  out_*       output     out_valid/out_ready  parse result, one per area
//  cfg_*       input      cfg_wr_en            timestamp enable bit
//
// One item is taken per cycle while in_ready is high; the parser state updates in the same cycle.
// The result of an area appears in the output register in the cycle after its
// last item is accepted.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset clears the parser and sets the timestamp enable to one.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_option_parser
  import tcpop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_opt_byte,
  input  wire logic        in_has_byte,
  input  wire logic [5:0]  in_area_length,
  input  wire logic        in_last_byte,
  input  wire logic [31:0] in_current_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_mss_seen,
  output logic [15:0]      out_mss_value,
  output logic [15:0]      out_eff_mss,
  output logic             out_wscale_seen,
  output logic [7:0]       out_wscale_value,
  output logic             out_sack_permitted,
  output logic             out_ts_seen,
  output logic [31:0]      out_ts_value,
  output logic [31:0]      out_ts_echo,
  output logic [31:0]      out_ts_update_time
);

  logic take;
  logic load;
  res_t res_nxt;

  // An item is taken whenever the result register has room.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign load     = take && in_last_byte;

  tcpop_walk u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .opt_byte     (in_opt_byte),
    .has_byte     (in_has_byte),
    .area_length  (in_area_length),
    .last_byte    (in_last_byte),
    .current_time (in_current_time),
    .res_nxt      (res_nxt)
  );

  tcpop_out u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .load               (load),
    .res_in             (res_nxt),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_mss_seen       (out_mss_seen),
    .out_mss_value      (out_mss_value),
    .out_eff_mss        (out_eff_mss),
    .out_wscale_seen    (out_wscale_seen),
    .out_wscale_value   (out_wscale_value),
    .out_sack_permitted (out_sack_permitted),
    .out_ts_seen        (out_ts_seen),
    .out_ts_value       (out_ts_value),
    .out_ts_echo        (out_ts_echo),
    .out_ts_update_time (out_ts_update_time)
  );

`ifndef ASSERT_OFF
  // Every accepted last item yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> out_valid)
    else $error("no result after last item of an area");
`endif

endmodule

`default_nettype wire
